[rtl/ppp_pkg.sv]
// Shared widths, register indexes and sideband type for the pinhole projection pipeline.
package ppp_pkg;

   localparam int COEF_W  = 20;   // Q1.18 matrix coefficient
   localparam int ROW_W   = 60;   // three packed coefficients
   localparam int WORLD_W = 32;   // Q16.16 input axis
   localparam int PROD_W  = 52;   // coefficient times axis
   localparam int TRANS_W = 50;   // translation aligned to Q.34
   localparam int CAM_W   = 54;   // camera coordinate, Q.34
   localparam int MAG_W   = 53;   // camera coordinate magnitude
   localparam int FOCAL_W = 24;   // Q16.8 focal length
   localparam int SPLIT_W = 27;   // low slice of the magnitude for the split multiply
   localparam int PP_W    = SPLIT_W + FOCAL_W;
   localparam int NUM_W   = MAG_W + FOCAL_W;   // |X| * f
   localparam int DEND_W  = NUM_W + 2;         // 2N + Z
   localparam int QUO_W   = 28;                // quotient bits, bounded by Z > f << 26
   localparam int REM_W   = MAG_W + 1;         // divisor 2Z and partial remainder
   localparam int COORD_W = 32;   // Q23.8 output
   localparam int SIZE_W  = 16;
   localparam int CSR_W   = 60;
   localparam int IDX_W   = 3;

   localparam logic [IDX_W-1:0] CSR_ROT0  = 3'd0;
   localparam logic [IDX_W-1:0] CSR_ROT1  = 3'd1;
   localparam logic [IDX_W-1:0] CSR_ROT2  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_TX    = 3'd3;
   localparam logic [IDX_W-1:0] CSR_TY    = 3'd4;
   localparam logic [IDX_W-1:0] CSR_TZ    = 3'd5;
   localparam logic [IDX_W-1:0] CSR_FOCAL = 3'd6;
   localparam logic [IDX_W-1:0] CSR_SIZE  = 3'd7;

   typedef struct packed {
      logic front;
      logic neg_x;
      logic neg_y;
   } side_type;

endpackage

[rtl/ppp_xform.sv]
// Rotation and translation: world point to camera coordinates in two stages.
module ppp_xform
   import ppp_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [WORLD_W-1:0]         world_x,
   input  logic signed [WORLD_W-1:0]         world_y,
   input  logic signed [WORLD_W-1:0]         world_z,
   input  logic [2:0][ROW_W-1:0]             rot,
   input  logic [2:0][WORLD_W-1:0]           trans,
   output logic                              cam_valid,
   output logic signed [2:0][CAM_W-1:0]      cam
);

   logic signed [WORLD_W-1:0] wv [3];
   logic signed [COEF_W-1:0]  coef [3][3];
   logic signed [PROD_W-1:0]  prod_in [3][3];
   logic signed [PROD_W-1:0]  prod_ff [3][3];
   logic signed [TRANS_W-1:0] trans_ff [3];
   logic                      prod_valid_ff;
   logic signed [2:0][CAM_W-1:0] cam_in;
   logic signed [2:0][CAM_W-1:0] cam_ff;
   logic                      cam_valid_ff;

   assign wv[0] = world_x;
   assign wv[1] = world_y;
   assign wv[2] = world_z;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            coef[r][c]    = $signed(rot[r][COEF_W*c +: COEF_W]);
            prod_in[r][c] = PROD_W'(coef[r][c]) * PROD_W'(wv[c]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         cam_in[r] = CAM_W'(prod_ff[r][0]) + CAM_W'(prod_ff[r][1])
                   + CAM_W'(prod_ff[r][2]) + CAM_W'(trans_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         cam_valid_ff  <= 1'b0;
      end else if (en) begin
         prod_valid_ff <= in_valid;
         cam_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= prod_in[r][c];
            end
            trans_ff[r] <= $signed({trans[r], 18'b0});
         end
         cam_ff <= cam_in;
      end
   end

   assign cam_valid = cam_valid_ff;
   assign cam       = cam_ff;

endmodule

[rtl/ppp_prep.sv]
// Depth test, magnitudes, split focal multiply and rounded dividend setup.
module ppp_prep
   import ppp_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          cam_valid,
   input  logic signed [2:0][CAM_W-1:0]  cam,
   input  logic [FOCAL_W-1:0]            focal,
   output logic                          dv_valid,
   output logic [1:0][DEND_W-1:0]        dend,
   output logic [REM_W-1:0]              divisor,
   output side_type                      side
);

   // stage 3: depth test and magnitudes
   logic signed [CAM_W-1:0] flim;
   logic [1:0][MAG_W-1:0]   mag_in;
   logic [1:0][MAG_W-1:0]   mag_ff;
   logic [MAG_W-1:0]        z_ff;
   side_type                side_in;
   side_type                s3_side_ff;
   logic                    s3_valid_ff;

   // stage 4: partial products
   logic [1:0][PP_W-1:0]    pp_lo_ff;
   logic [1:0][PP_W-1:0]    pp_hi_ff;
   logic [MAG_W-1:0]        s4_z_ff;
   side_type                s4_side_ff;
   logic                    s4_valid_ff;

   // stage 5: dividend and divisor
   logic [1:0][NUM_W-1:0]   num;
   logic [1:0][DEND_W-1:0]  dend_in;
   logic [1:0][DEND_W-1:0]  dend_ff;
   logic [REM_W-1:0]        divisor_ff;
   side_type                s5_side_ff;
   logic                    s5_valid_ff;

   assign flim = CAM_W'({focal, 26'b0});

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         mag_in[l] = cam[l][CAM_W-1] ? MAG_W'(-cam[l]) : MAG_W'(cam[l]);
      end
      // element select of a packed array is unsigned
      side_in.front = $signed(cam[2]) > flim;
      side_in.neg_x = cam[0][CAM_W-1];
      side_in.neg_y = cam[1][CAM_W-1];
   end

   // round to nearest: (2N + Z) / 2Z
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         num[l]     = (NUM_W'(pp_hi_ff[l]) << SPLIT_W) + NUM_W'(pp_lo_ff[l]);
         dend_in[l] = {num[l], 1'b0} + DEND_W'(s4_z_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= cam_valid;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff     <= mag_in;
         z_ff       <= MAG_W'(cam[2]);
         s3_side_ff <= side_in;
         for (int l = 0; l < 2; l++) begin
            pp_lo_ff[l] <= PP_W'(mag_ff[l][SPLIT_W-1:0]) * PP_W'(focal);
            pp_hi_ff[l] <= PP_W'(mag_ff[l][MAG_W-1:SPLIT_W]) * PP_W'(focal);
         end
         s4_z_ff    <= z_ff;
         s4_side_ff <= s3_side_ff;
         dend_ff    <= dend_in;
         divisor_ff <= {s4_z_ff, 1'b0};
         s5_side_ff <= s4_side_ff;
      end
   end

   assign dv_valid = s5_valid_ff;
   assign dend     = dend_ff;
   assign divisor  = divisor_ff;
   assign side     = s5_side_ff;

endmodule

[rtl/ppp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
module ppp_div
   import ppp_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [1:0][DEND_W-1:0]      dend,
   input  logic [REM_W-1:0]            divisor,
   input  side_type                    in_side,
   output logic                        out_valid,
   output logic [1:0][QUO_W-1:0]       quo,
   output side_type                    out_side
);

   logic                        valid_ff [QUO_W];
   logic [1:0][REM_W-1:0]       rem_ff   [QUO_W];
   logic [1:0][QUO_W-1:0]       low_ff   [QUO_W];
   logic [1:0][QUO_W-1:0]       quo_ff   [QUO_W];
   logic [REM_W-1:0]            div_ff   [QUO_W];
   side_type                    side_ff  [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic                  src_valid;
      logic [1:0][REM_W-1:0] src_rem;
      logic [1:0][QUO_W-1:0] src_low;
      logic [1:0][QUO_W-1:0] src_quo;
      logic [REM_W-1:0]      src_div;
      side_type              src_side;
      logic [1:0][REM_W:0]   trial;
      logic [1:0]            ge;

      if (k == 0) begin : g_first
         // quotient stays below 2^QUO_W, so the top dividend bits are below the divisor
         always_comb begin
            src_valid = in_valid;
            for (int l = 0; l < 2; l++) begin
               src_rem[l] = REM_W'(dend[l][DEND_W-1:QUO_W]);
               src_low[l] = dend[l][QUO_W-1:0];
               src_quo[l] = '0;
            end
            src_div  = divisor;
            src_side = in_side;
         end
      end else begin : g_next
         always_comb begin
            src_valid = valid_ff[k-1];
            src_rem   = rem_ff[k-1];
            src_low   = low_ff[k-1];
            src_quo   = quo_ff[k-1];
            src_div   = div_ff[k-1];
            src_side  = side_ff[k-1];
         end
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            trial[l] = {src_rem[l], src_low[l][QUO_W-1]};
            ge[l]    = trial[l] >= {1'b0, src_div};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 2; l++) begin
               rem_ff[k][l] <= ge[l] ? REM_W'(trial[l] - {1'b0, src_div}) : REM_W'(trial[l]);
               low_ff[k][l] <= src_low[l] << 1;
               quo_ff[k][l] <= {src_quo[l][QUO_W-2:0], ge[l]};
            end
            div_ff[k]  <= src_div;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign quo       = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

[rtl/pinhole_point_projection.sv]
// Top level: configuration registers, pipeline and result register of the point projector.
//
// Usage:
//  - Request channel (req_*): one world point per transaction, signed Q16.16 per axis.
//    A transaction completes on a rising edge with req_valid high and req_stall low.
//  - Response channel (rsp_*): one result per request, in request order: column and
//    row in signed Q23.8 plus in_front. When in_front is 0 both coordinates are 0.
//  - Configuration (csr_*): csr_write with csr_index and csr_wdata writes one register.
//    Write only while no request is in flight.
//  - Pipeline: from request transaction to rsp_valid there are two stages for the
//    matrix multiply and sum, three for depth test and dividend setup, 28 divider
//    stages (one quotient bit each) and the result register.
//  - Throughput: one point per cycle unless stalled; the divider is fully pipelined.
//  - Stall: the whole pipeline holds while a result waits with rsp_stall high;
//    req_stall then goes high in the same cycle. Nothing is dropped or repeated.
//  - Reset (synchronous): empties the pipeline and loads identity rotation, zero
//    translation, focal length 1.0 and zero image size.
module pinhole_point_projection
   import ppp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [WORLD_W-1:0]  req_world_x,
   input  logic signed [WORLD_W-1:0]  req_world_y,
   input  logic signed [WORLD_W-1:0]  req_world_z,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [COORD_W-1:0]  rsp_image_x,
   output logic signed [COORD_W-1:0]  rsp_image_y,
   output logic                       rsp_in_front,
   input  logic                       csr_write,
   input  logic [IDX_W-1:0]           csr_index,
   input  logic [CSR_W-1:0]           csr_wdata
);

   // configuration
   logic [2:0][ROW_W-1:0]    rot_ff;
   logic [2:0][WORLD_W-1:0]  trans_ff;
   logic [FOCAL_W-1:0]       focal_ff;
   logic [2*SIZE_W-1:0]      size_ff;

   // pipeline advance: move unless a finished result is held back
   logic                     en;

   logic                          cam_valid;
   logic signed [2:0][CAM_W-1:0]  cam;
   logic                          dv_valid;
   logic [1:0][DEND_W-1:0]        dend;
   logic [REM_W-1:0]              divisor;
   side_type                      dv_side;
   logic                          q_valid;
   logic [1:0][QUO_W-1:0]         quo;
   side_type                      q_side;

   logic [1:0][COORD_W-1:0]  img_in;
   logic [1:0][COORD_W-1:0]  img_ff;
   logic [1:0]               neg;
   logic                     front_ff;
   logic                     rsp_valid_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= ROW_W'(1) << 18;
         rot_ff[1] <= ROW_W'(1) << 38;
         rot_ff[2] <= ROW_W'(1) << 58;
         trans_ff  <= '0;
         focal_ff  <= FOCAL_W'(256);
         size_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ROT0:  rot_ff[0]   <= csr_wdata;
            CSR_ROT1:  rot_ff[1]   <= csr_wdata;
            CSR_ROT2:  rot_ff[2]   <= csr_wdata;
            CSR_TX:    trans_ff[0] <= csr_wdata[WORLD_W-1:0];
            CSR_TY:    trans_ff[1] <= csr_wdata[WORLD_W-1:0];
            CSR_TZ:    trans_ff[2] <= csr_wdata[WORLD_W-1:0];
            CSR_FOCAL: focal_ff    <= csr_wdata[FOCAL_W-1:0];
            CSR_SIZE:  size_ff     <= csr_wdata[2*SIZE_W-1:0];
            default:   ;
         endcase
      end
   end

   ppp_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .world_x   (req_world_x),
      .world_y   (req_world_y),
      .world_z   (req_world_z),
      .rot       (rot_ff),
      .trans     (trans_ff),
      .cam_valid (cam_valid),
      .cam       (cam)
   );

   ppp_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cam_valid (cam_valid),
      .cam       (cam),
      .focal     (focal_ff),
      .dv_valid  (dv_valid),
      .dend      (dend),
      .divisor   (divisor),
      .side      (dv_side)
   );

   ppp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_valid),
      .dend      (dend),
      .divisor   (divisor),
      .in_side   (dv_side),
      .out_valid (q_valid),
      .quo       (quo),
      .out_side  (q_side)
   );

   // Apply sign and add half the image size (size << 7 in Q8). The quotient is
   // below 2^28 and the offset below 2^23, so the sum never reaches the 32-bit limits.
   assign neg[0] = q_side.neg_x;
   assign neg[1] = q_side.neg_y;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (!q_side.front) begin
            img_in[l] = '0;
         end else begin
            img_in[l] = (neg[l] ? -COORD_W'(quo[l]) : COORD_W'(quo[l]))
                      + COORD_W'({size_ff[SIZE_W*l +: SIZE_W], 7'b0});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && q_valid) begin
         img_ff   <= img_in;
         front_ff <= q_side.front;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_image_x  = img_ff[0];
   assign rsp_image_y  = img_ff[1];
   assign rsp_in_front = front_ff;

endmodule

[rtl/ppp_chk.sv]
// Port-level checker for the point projector, bound to the top level.
module ppp_chk
   import ppp_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [COORD_W-1:0]  rsp_image_x,
   input logic signed [COORD_W-1:0]  rsp_image_y,
   input logic                       rsp_in_front
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_image_x)
         && $stable(rsp_image_y) && $stable(rsp_in_front))
      else $error("stalled response changed");

   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_front |-> rsp_image_x == 0 && rsp_image_y == 0)
      else $error("point behind camera with nonzero coordinates");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow held response");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind pinhole_point_projection ppp_chk u_ppp_chk (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_image_x  (rsp_image_x),
   .rsp_image_y  (rsp_image_y),
   .rsp_in_front (rsp_in_front)
);

[dv/tb_pinhole_point_projection.sv]
// Self-checking pinhole projector testbench: directed and random points through a scoreboard.
`timescale 1ns / 100ps

module tb_pinhole_point_projection;
   import ppp_pkg::*;

   typedef struct {
      logic signed [31:0] img_x;
      logic signed [31:0] img_y;
      logic               front;
   } pixel_type;

   // Camera settings mirror plus the queue of projected pixels still owed by the block.
   class projection_scoreboard;
      logic [59:0] rot [3];
      logic [31:0] trans [3];
      logic [23:0] focal;
      logic [31:0] size;
      pixel_type   pending [$];
      int          errors;

      function new();
         rot[0] = 60'h1 << 18;
         rot[1] = 60'h1 << 38;
         rot[2] = 60'h1 << 58;
         trans[0] = 0;
         trans[1] = 0;
         trans[2] = 0;
         focal = 24'd256;
         size = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [IDX_W-1:0] idx, logic [59:0] val);
         case (idx)
            CSR_ROT0:  rot[0] = val;
            CSR_ROT1:  rot[1] = val;
            CSR_ROT2:  rot[2] = val;
            CSR_TX:    trans[0] = val[31:0];
            CSR_TY:    trans[1] = val[31:0];
            CSR_TZ:    trans[2] = val[31:0];
            CSR_FOCAL: focal = val[23:0];
            default:   size = val[31:0];
         endcase
      endfunction

      // Rounded X*f/Z in Q8 (ties away from zero), clamp, center offset, saturate.
      function logic signed [31:0] scale_axis(logic signed [63:0] num, logic signed [63:0] z,
                                              logic [15:0] half);
         logic [127:0] mag;
         logic [127:0] q;
         logic signed [127:0] v;
         mag = (num < 0) ? -num : num;
         q = (2 * mag * focal + z) / (2 * z);
         if (q > (128'd1 << 40)) q = 128'd1 << 40;
         v = (num < 0) ? -$signed(q) : $signed(q);
         v = v + ($signed({112'd0, half}) <<< 7);
         if (v > 128'sd2147483647) v = 128'sd2147483647;
         if (v < -128'sd2147483648) v = -128'sd2147483648;
         return v[31:0];
      endfunction

      function void note_point(logic signed [31:0] wx, logic signed [31:0] wy,
                               logic signed [31:0] wz);
         logic signed [63:0] cam [3];
         logic signed [63:0] w [3];
         logic signed [19:0] c;
         pixel_type px;
         w[0] = wx;
         w[1] = wy;
         w[2] = wz;
         for (int r = 0; r < 3; r++) begin
            cam[r] = $signed(trans[r]) * 64'sd262144;
            for (int j = 0; j < 3; j++) begin
               c = rot[r][20*j +: 20];
               cam[r] += c * w[j];
            end
         end
         if (cam[2] > $signed({40'd0, focal} << 26)) begin
            px.img_x = scale_axis(cam[0], cam[2], size[15:0]);
            px.img_y = scale_axis(cam[1], cam[2], size[31:16]);
            px.front = 1'b1;
         end else begin
            px.img_x = 0;
            px.img_y = 0;
            px.front = 1'b0;
         end
         pending.push_back(px);
      endfunction

      function void check_pixel(logic signed [31:0] ix, logic signed [31:0] iy, logic fr);
         pixel_type px;
         if (pending.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
            return;
         end
         px = pending.pop_front();
         if (ix !== px.img_x) begin
            $error("image_x expected %0d actual %0d", px.img_x, ix);
            errors++;
         end
         if (iy !== px.img_y) begin
            $error("image_y expected %0d actual %0d", px.img_y, iy);
            errors++;
         end
         if (fr !== px.front) begin
            $error("in_front expected %0d actual %0d", px.front, fr);
            errors++;
         end
      endfunction
   endclass

   localparam int LATENCY   = 34;
   localparam int STALL_CAP = 2000;   // idle cycles without any transaction

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_world_x, req_world_y, req_world_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_image_x, rsp_image_y;
   logic               rsp_in_front;
   logic               csr_write;
   logic [IDX_W-1:0]   csr_index;
   logic [CSR_W-1:0]   csr_wdata;

   projection_scoreboard sb;
   bit                   no_resp_stall;   // phase with no receiver idling
   bit                   no_req_gaps;     // phase with back-to-back requests
   int                   idle_cycles;

   pinhole_point_projection dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: random stall per result, check on every accepted transaction.
   initial begin
      int wait_n;
      rsp_stall = 1'b1;
      @(posedge clock iff !reset);
      forever begin
         wait_n = no_resp_stall ? 0 : $urandom_range(0, 11);
         rsp_stall <= (wait_n != 0);
         repeat (wait_n) @(posedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_pixel(rsp_image_x, rsp_image_y, rsp_in_front);
      end
   end

   // Watchdog: counts cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_CAP) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [59:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   // One request transaction; valid stays high straight into the next point when no gap.
   task automatic send_point(logic signed [31:0] wx, logic signed [31:0] wy,
                             logic signed [31:0] wz);
      int gap;
      gap = no_req_gaps ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_world_x <= wx;
      req_world_y <= wy;
      req_world_z <= wz;
      do @(posedge clock); while (req_stall);
      sb.note_point(wx, wy, wz);
   endtask

   // Pipeline drained: no results owed, then the latency passes again for safety.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_axis();
      case ($urandom_range(0, 5))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2, 3:    return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
         default: return $urandom();
      endcase
   endfunction

   // Mostly near-identity rows so many points land in front; rest is raw bits.
   function automatic logic [59:0] rand_row(int diag);
      logic [59:0] r;
      if ($urandom_range(0, 3) == 0) return 60'({$urandom(), $urandom()});
      r = 0;
      for (int j = 0; j < 3; j++)
         r[20*j +: 20] = (j == diag) ? 20'(20'h40000 - $urandom_range(0, 20'h1000))
                                     : 20'($signed($urandom_range(0, 20'h8000)) - 16'sh4000);
      return r;
   endfunction

   initial begin
      logic [31:0] edge_vals [6];
      sb = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_world_x = 0;
      req_world_y = 0;
      req_world_z = 0;
      csr_write   = 1'b0;
      csr_index   = CSR_ROT0;
      csr_wdata   = 0;
      no_resp_stall = 0;
      no_req_gaps   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, depth at and around the focal length, field extremes.
      edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0001_0000,
                    32'h0000_0100};
      send_point(0, 0, 32'h0001_0000);   // depth equal to focal: not in front
      send_point(0, 0, 32'h0001_0001);   // just beyond
      send_point(32'h0001_0000, -32'sh0001_0000, 32'h0000_0080);
      for (int i = 0; i < 6; i++)
         send_point(edge_vals[i], edge_vals[5-i], edge_vals[(i+2)%6]);
      drain();

      // Zero focal length, image center, translation: front exactly when depth > 0.
      write_reg(CSR_FOCAL, 60'd0);
      write_reg(CSR_SIZE, 60'hffff_ffff);
      write_reg(CSR_TZ, 60'h0000_0000);
      send_point(5, 5, 0);
      send_point(5, -5, 1);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      drain();
      write_reg(CSR_FOCAL, 60'hff_ffff);   // largest focal: saturation
      write_reg(CSR_TX, 60'h7fff_ffff);
      write_reg(CSR_TY, 60'h8000_0000);
      write_reg(CSR_TZ, 60'h7fff_ffff);
      write_reg(CSR_ROT2, 60'h7ffff << 40);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_point(0, 0, 32'h8000_0000);
      drain();
      write_reg(CSR_ROT0, 60'hfffff_fffff_fffff);
      write_reg(CSR_ROT1, 60'h80000_80000_80000);
      write_reg(CSR_ROT2, 60'h7ffff_7ffff_7ffff);
      write_reg(CSR_TZ, 60'h8000_0000);
      write_reg(CSR_SIZE, 60'h0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      drain();

      // Random phases: new camera each phase, points mostly in a plausible volume.
      for (int ph = 0; ph < 9; ph++) begin
         no_resp_stall = (ph == 3);
         no_req_gaps   = (ph == 3 || ph == 6);
         write_reg(CSR_ROT0, rand_row(0));
         write_reg(CSR_ROT1, rand_row(1));
         write_reg(CSR_ROT2, rand_row(2));
         write_reg(CSR_TX, $urandom_range(0, 3) == 0 ? $urandom() : 60'($urandom_range(0, 255)));
         write_reg(CSR_TY, $urandom_range(0, 3) == 0 ? $urandom() : 60'($urandom_range(0, 255)));
         write_reg(CSR_TZ, $urandom_range(0, 3) == 0 ? $urandom()
                                                     : 60'($urandom_range(0, 32'h0080_0000)));
         write_reg(CSR_FOCAL, $urandom_range(0, 3) == 0 ? $urandom()
                                                        : 60'($urandom_range(0, 24'h04_0000)));
         write_reg(CSR_SIZE, $urandom());
         repeat (100) begin
            if ($urandom_range(0, 4) == 0)
               send_point($urandom(), $urandom(), $urandom());
            else
               send_point(rand_axis(), rand_axis(),
                          $urandom_range(1, 32'h0100_0000));
         end
         drain();
      end

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[files.f]
rtl/ppp_pkg.sv
rtl/ppp_xform.sv
rtl/ppp_prep.sv
rtl/ppp_div.sv
rtl/pinhole_point_projection.sv
rtl/ppp_chk.sv
dv/tb_pinhole_point_projection.sv
